// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the port checker of this project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/btog_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btog_pkg
// Types and constants of the bus trace operand gatherer.
// ----------------------------------------------------------------------------
package btog_pkg;

	localparam int WINDOW       = 8;
	localparam int WIN_DEPTH    = WINDOW - 1;
	localparam int FILL_W       = $clog2(WINDOW);
	localparam int MAX_OPERANDS = 3;
	localparam int QUEUE_DEPTH  = 2;
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

	localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WIN_DEPTH);
	localparam logic [FILL_W-1:0] FILL_ONE  = FILL_W'(1);
	localparam logic [QPTR_W-1:0] QPTR_LAST = QPTR_W'(QUEUE_DEPTH - 1);
	localparam logic [QPTR_W-1:0] QPTR_ONE  = QPTR_W'(1);
	localparam logic [QCNT_W-1:0] QCNT_FULL = QCNT_W'(QUEUE_DEPTH);
	localparam logic [QCNT_W-1:0] QCNT_ONE  = QCNT_W'(1);

	localparam logic OP_RECORD = 1'b0;
	localparam logic OP_FLUSH  = 1'b1;

	typedef struct packed {
		logic        op;
		logic [15:0] bus_address;
		logic [7:0]  bus_data;
		logic [7:0]  bus_flags;
	} in_beat_t;

	typedef struct packed {
		logic [15:0] cycle_address;
		logic [7:0]  cycle_data;
		logic [7:0]  cycle_flags;
		logic [7:0]  operand_one;
		logic [7:0]  operand_two;
		logic [7:0]  operand_three;
		logic [1:0]  operand_count;
		logic        last_of_run;
	} out_beat_t;

	typedef struct packed {
		logic [7:0]  flags;
		logic [7:0]  data;
		logic [15:0] address;
	} record_t;

	typedef struct packed {
		logic [15:0] address;
		logic [7:0]  data;
	} follower_t;

	typedef struct packed {
		record_t                       rec;
		follower_t [WIN_DEPTH-1:0]     fol;
		logic                          last;
	} job_t;

endpackage

// ===== design/bus_trace_operand_gatherer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bus_trace_operand_gatherer_top
// Annotates bus-cycle records with the data of the address run that follows.
// ----------------------------------------------------------------------------
// Records are taken one per clock while rec_stall is low. Each record is held
// in a seven-entry window and leaves annotated when the seventh record after
// it arrives; its result beat passes through the job queue and then the output
// register. A flush beat stalls the record channel while the window shifts out
// its pending records, one record a clock while the queue is not full, into the
// two-entry job queue. Results can be stalled independently: the queue absorbs
// up to two jobs before the record channel stalls.
module bus_trace_operand_gatherer_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rec_valid,
	output logic                rec_stall,
	input  btog_pkg::in_beat_t  rec_beat,
	output logic                ann_valid,
	input  logic                ann_stall,
	output btog_pkg::out_beat_t ann_beat
);

	logic           push_valid;
	btog_pkg::job_t push_job;
	logic           q_full;
	logic           q_valid;
	logic           q_pop;
	btog_pkg::job_t q_job;

	btog_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.rec_valid  (rec_valid),
		.rec_stall  (rec_stall),
		.rec_beat   (rec_beat),
		.push_valid (push_valid),
		.push_job   (push_job),
		.q_full     (q_full)
	);

	btog_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push_valid),
		.push_job  (push_job),
		.full      (q_full),
		.pop_valid (q_valid),
		.pop       (q_pop),
		.pop_job   (q_job)
	);

	btog_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (q_valid),
		.job       (q_job),
		.pop       (q_pop),
		.ann_valid (ann_valid),
		.ann_stall (ann_stall),
		.ann_beat  (ann_beat)
	);

endmodule

// ===== design/btog_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btog_front
// Window of pending records; issues one annotation job per released record.
// ----------------------------------------------------------------------------
module btog_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rec_valid,
	output logic               rec_stall,
	input  btog_pkg::in_beat_t rec_beat,
	output logic               push_valid,
	output btog_pkg::job_t     push_job,
	input  logic               q_full
);

	btog_pkg::record_t                   win_q [btog_pkg::WIN_DEPTH];
	logic [btog_pkg::FILL_W-1:0]         fill_q;
	logic                                flush_q;
	btog_pkg::record_t                   rec_in;
	logic                                acc;
	logic                                win_full;

	// entries at and above fill_q are always zero
	assign rec_in.address = rec_beat.bus_address;
	assign rec_in.data    = rec_beat.bus_data;
	assign rec_in.flags   = rec_beat.bus_flags;

	assign rec_stall  = flush_q || q_full;
	assign acc        = rec_valid && !rec_stall;
	assign win_full   = (fill_q == btog_pkg::FILL_FULL);
	assign push_valid = (acc && rec_beat.op == btog_pkg::OP_RECORD && win_full)
		|| (flush_q && !q_full);

	always_comb begin
		push_job.rec = win_q[0];
		for (int j = 0; j < btog_pkg::WIN_DEPTH - 1; j++) begin
			push_job.fol[j].address = win_q[j+1].address;
			push_job.fol[j].data    = win_q[j+1].data;
		end
		if (flush_q) begin
			push_job.fol[btog_pkg::WIN_DEPTH-1] = '0;
		end else begin
			push_job.fol[btog_pkg::WIN_DEPTH-1].address = rec_in.address;
			push_job.fol[btog_pkg::WIN_DEPTH-1].data    = rec_in.data;
		end
		push_job.last = flush_q && (fill_q == btog_pkg::FILL_ONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < btog_pkg::WIN_DEPTH; i++) begin
				win_q[i] <= '0;
			end
			fill_q  <= '0;
			flush_q <= 1'b0;
		end else if (flush_q) begin
			if (!q_full) begin
				for (int i = 0; i < btog_pkg::WIN_DEPTH - 1; i++) begin
					win_q[i] <= win_q[i+1];
				end
				win_q[btog_pkg::WIN_DEPTH-1] <= '0;
				fill_q <= fill_q - btog_pkg::FILL_ONE;
				if (fill_q == btog_pkg::FILL_ONE) begin
					flush_q <= 1'b0;
				end
			end
		end else if (acc) begin
			if (rec_beat.op == btog_pkg::OP_FLUSH) begin
				if (fill_q != '0) begin
					flush_q <= 1'b1;
				end
			end else if (win_full) begin
				for (int i = 0; i < btog_pkg::WIN_DEPTH - 1; i++) begin
					win_q[i] <= win_q[i+1];
				end
				win_q[btog_pkg::WIN_DEPTH-1] <= rec_in;
			end else begin
				for (int i = 0; i < btog_pkg::WIN_DEPTH; i++) begin
					if (int'(fill_q) == i) begin
						win_q[i] <= rec_in;
					end
				end
				fill_q <= fill_q + btog_pkg::FILL_ONE;
			end
		end
	end

endmodule

// ===== design/btog_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btog_queue
// Short job queue between the window front end and the annotation back end.
// ----------------------------------------------------------------------------
module btog_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  btog_pkg::job_t push_job,
	output logic           full,
	output logic           pop_valid,
	input  logic           pop,
	output btog_pkg::job_t pop_job
);

	btog_pkg::job_t              slot_q [btog_pkg::QUEUE_DEPTH];
	logic [btog_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [btog_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [btog_pkg::QCNT_W-1:0] cnt_q;

	assign full      = (cnt_q == btog_pkg::QCNT_FULL);
	assign pop_valid = (cnt_q != '0);
	assign pop_job   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == btog_pkg::QPTR_LAST) ? '0
					: wr_ptr_q + btog_pkg::QPTR_ONE;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == btog_pkg::QPTR_LAST) ? '0
					: rd_ptr_q + btog_pkg::QPTR_ONE;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + btog_pkg::QCNT_ONE;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - btog_pkg::QCNT_ONE;
			end
		end
	end

endmodule

// ===== design/btog_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btog_back
// Scans a job's followers for the address run and registers the result beat.
// ----------------------------------------------------------------------------
module btog_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                job_valid,
	input  btog_pkg::job_t      job,
	output logic                pop,
	output logic                ann_valid,
	input  logic                ann_stall,
	output btog_pkg::out_beat_t ann_beat
);

	logic [15:0]                    a1;
	logic [15:0]                    a2;
	logic [15:0]                    a3;
	logic [btog_pkg::WIN_DEPTH-1:0] m1;
	logic [btog_pkg::WIN_DEPTH-1:0] m2;
	logic [btog_pkg::WIN_DEPTH-1:0] m3;
	btog_pkg::out_beat_t            ann;
	logic                           out_valid_q;
	btog_pkg::out_beat_t            out_q;

	assign a1 = job.rec.address + 16'd1;
	assign a2 = job.rec.address + 16'd2;
	assign a3 = job.rec.address + 16'd3;

	always_comb begin
		for (int j = 0; j < btog_pkg::WIN_DEPTH; j++) begin
			m1[j] = (job.fol[j].address == a1);
			m2[j] = (job.fol[j].address == a2);
			m3[j] = (job.fol[j].address == a3);
		end
	end

	// run state walks the followers in order: next expected offset is count+1
	always_comb begin
		ann.cycle_address = job.rec.address;
		ann.cycle_data    = job.rec.data;
		ann.cycle_flags   = job.rec.flags;
		ann.operand_one   = '0;
		ann.operand_two   = '0;
		ann.operand_three = '0;
		ann.operand_count = '0;
		ann.last_of_run   = job.last;
		for (int j = 0; j < btog_pkg::WIN_DEPTH; j++) begin
			unique case (ann.operand_count)
				2'd0: begin
					if (m1[j]) begin
						ann.operand_one   = job.fol[j].data;
						ann.operand_count = 2'd1;
					end
				end
				2'd1: begin
					if (m2[j]) begin
						ann.operand_two   = job.fol[j].data;
						ann.operand_count = 2'd2;
					end
				end
				2'd2: begin
					if (m3[j]) begin
						ann.operand_three = job.fol[j].data;
						ann.operand_count = 2'd3;
					end
				end
				default: ;
			endcase
		end
	end

	assign pop       = job_valid && (!out_valid_q || !ann_stall);
	assign ann_valid = out_valid_q;
	assign ann_beat  = out_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= ann;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (!ann_stall) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== design/btog_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btog_checker
// Port-level assertions for the bus trace operand gatherer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module btog_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                rec_valid,
	input logic                rec_stall,
	input btog_pkg::in_beat_t  rec_beat,
	input logic                ann_valid,
	input logic                ann_stall,
	input btog_pkg::out_beat_t ann_beat
);

	`ASSERT_ALWAYS(a_no_beat_in_reset, clk, !arst_n |-> !ann_valid, "result beat during reset")

	`ASSERT_CLK(a_valid_held, clk, arst_n, ann_valid && ann_stall |=> ann_valid, "result dropped")

	`ASSERT_CLK(a_beat_held, clk, arst_n, ann_valid && ann_stall |=> $stable(ann_beat), "result changed")

	`ASSERT_CLK(a_unused_ops_zero, clk, arst_n, ann_valid |-> (ann_beat.operand_count == 2'd3 || ann_beat.operand_three == 8'd0) && (ann_beat.operand_count == 2'd3 || ann_beat.operand_count == 2'd2 || ann_beat.operand_two == 8'd0) && (ann_beat.operand_count != 2'd0 || ann_beat.operand_one == 8'd0), "operand beyond count")

	`ASSERT_CLK(a_flush_stalls, clk, arst_n, rec_valid && !rec_stall && rec_beat.op == btog_pkg::OP_FLUSH && ann_valid && ann_stall |=> ann_valid, "flush lost result")

endmodule

bind bus_trace_operand_gatherer_top btog_checker u_btog_checker (.*);

// ===== test/bus_trace_operand_gatherer_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bus_trace_operand_gatherer_checker
// Scoreboard for the bus trace operand gatherer.
// ----------------------------------------------------------------------------
// Watches both channels. It keeps its own copy of the record window, predicts
// the annotated records that every accepted beat releases, and compares each
// result beat field by field against the oldest prediction in order.
module bus_trace_operand_gatherer_checker
	import btog_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      rec_valid,
	input  logic      rec_stall,
	input  in_beat_t  rec_beat,
	input  logic      ann_valid,
	input  logic      ann_stall,
	input  out_beat_t ann_beat,
	output int        mismatches,
	output int        outstanding,
	output int        results_seen
);

	record_t [WIN_DEPTH-1:0] window_q;
	int                      window_fill;
	out_beat_t               expected_annotations[$];

	// seq[0] is the record, seq[1..] its followers, zero past the end
	function automatic out_beat_t annotate_record(input record_t [WINDOW-1:0] seq,
			input logic last_flag);
		out_beat_t                    res;
		logic [MAX_OPERANDS-1:0][7:0] ops;
		logic [15:0]                  want_addr;
		int                           found;
		ops = '0;
		found = 0;
		want_addr = seq[0].address + 16'd1;
		for (int n = 1; n < WINDOW; n++) begin
			if (found < MAX_OPERANDS && seq[n].address == want_addr) begin
				ops[found] = seq[n].data;
				found++;
				want_addr = want_addr + 16'd1;
			end
		end
		res.cycle_address = seq[0].address;
		res.cycle_data    = seq[0].data;
		res.cycle_flags   = seq[0].flags;
		res.operand_one   = ops[0];
		res.operand_two   = ops[1];
		res.operand_three = ops[2];
		res.operand_count = 2'(found);
		res.last_of_run   = last_flag;
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		$display("%0t ns: mismatch on %s, got %0h, expected %0h", $time, what, got, want);
		mismatches++;
	endtask

	task automatic compare_field(input string what, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want)
			report_mismatch(what, got, want);
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		record_t              rec;
		record_t [WINDOW-1:0] seq;
		out_beat_t            want;
		if (!arst_n) begin
			window_q = '0;
			window_fill = 0;
			expected_annotations.delete();
			mismatches = 0;
			results_seen = 0;
			outstanding <= 0;
		end else begin
			if (rec_valid && !rec_stall) begin
				if (rec_beat.op == OP_RECORD) begin
					rec.flags   = rec_beat.bus_flags;
					rec.data    = rec_beat.bus_data;
					rec.address = rec_beat.bus_address;
					if (window_fill == WIN_DEPTH) begin
						// oldest record now has all its followers
						seq = {rec, window_q};
						expected_annotations.push_back(annotate_record(seq, 1'b0));
						window_q = {rec, window_q[WIN_DEPTH-1:1]};
					end else begin
						window_q[window_fill] = rec;
						window_fill++;
					end
				end else begin
					for (int k = 0; k < window_fill; k++) begin
						seq = '0;
						for (int j = 0; j < WINDOW; j++) begin
							if (k + j < window_fill)
								seq[j] = window_q[k + j];
						end
						expected_annotations.push_back(
							annotate_record(seq, k == window_fill - 1));
					end
					window_q = '0;
					window_fill = 0;
				end
			end
			if (ann_valid && !ann_stall) begin
				if (expected_annotations.size() == 0) begin
					report_mismatch("result beat with none pending", ann_beat.cycle_address,
						16'h0);
				end else begin
					want = expected_annotations.pop_front();
					results_seen++;
					compare_field("cycle_address", ann_beat.cycle_address, want.cycle_address);
					compare_field("cycle_data", 16'(ann_beat.cycle_data),
						16'(want.cycle_data));
					compare_field("cycle_flags", 16'(ann_beat.cycle_flags),
						16'(want.cycle_flags));
					compare_field("operand_one", 16'(ann_beat.operand_one),
						16'(want.operand_one));
					compare_field("operand_two", 16'(ann_beat.operand_two),
						16'(want.operand_two));
					compare_field("operand_three", 16'(ann_beat.operand_three),
						16'(want.operand_three));
					compare_field("operand_count", 16'(ann_beat.operand_count),
						16'(want.operand_count));
					compare_field("last_of_run", 16'(ann_beat.last_of_run),
						16'(want.last_of_run));
				end
			end
			outstanding <= expected_annotations.size();
		end
	end

endmodule

// ===== test/tb_bus_trace_operand_gatherer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bus_trace_operand_gatherer_top
// Regression bench for the bus trace operand gatherer.
// ----------------------------------------------------------------------------
// Drives a directed set of address runs, wraps and flushes, then a long
// result hold that backs the block up, then mostly sequential instruction
// fetch streams with noise cycles and flushes mixed in. Both channels idle at
// random. The checker beside the block predicts and compares every result.
module tb_bus_trace_operand_gatherer_top;
	import btog_pkg::*;

	localparam int LONG_HOLD    = 120;
	localparam int HOLD_RECORDS = 40;
	localparam int RANDOM_ITEMS = 220;

	logic      clk;
	logic      arst_n;
	logic      rec_valid;
	logic      rec_stall;
	in_beat_t  rec_beat;
	logic      ann_valid;
	logic      ann_stall;
	out_beat_t ann_beat;

	int   mismatches;
	int   outstanding;
	int   results_seen;
	int   hold_requests = 0;
	logic holding;
	logic no_gaps;
	int   records_sent;
	int   flushes_sent;

	bus_trace_operand_gatherer_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.rec_valid (rec_valid),
		.rec_stall (rec_stall),
		.rec_beat  (rec_beat),
		.ann_valid (ann_valid),
		.ann_stall (ann_stall),
		.ann_beat  (ann_beat)
	);

	bus_trace_operand_gatherer_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.rec_valid    (rec_valid),
		.rec_stall    (rec_stall),
		.rec_beat     (rec_beat),
		.ann_valid    (ann_valid),
		.ann_stall    (ann_stall),
		.ann_beat     (ann_beat),
		.mismatches   (mismatches),
		.outstanding  (outstanding),
		.results_seen (results_seen)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic in_beat_t rec_beat_of(input logic [15:0] addr, input logic [7:0] data,
			input logic [7:0] flags);
		in_beat_t b;
		b.op          = OP_RECORD;
		b.bus_address = addr;
		b.bus_data    = data;
		b.bus_flags   = flags;
		return b;
	endfunction

	function automatic in_beat_t flush_beat(input logic [15:0] addr, input logic [7:0] data,
			input logic [7:0] flags);
		in_beat_t b;
		b = rec_beat_of(addr, data, flags);
		b.op = OP_FLUSH;
		return b;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 2);
		else if (r < 95)
			return $urandom_range(3, 6);
		else
			return $urandom_range(10, 30);
	endfunction

	// entered and left at a rising edge
	task automatic send_beat(input in_beat_t b);
		int   gap;
		logic took;
		rec_valid <= 1'b1;
		rec_beat  <= b;
		took = 1'b0;
		while (!took) begin
			@(negedge clk);
			took = !rec_stall;
			@(posedge clk);
		end
		if (b.op == OP_RECORD)
			records_sent++;
		else
			flushes_sent++;
		gap = no_gaps ? 0 : pick_gap();
		if (gap > 0) begin
			rec_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		rec_valid <= 1'b0;
		@(posedge clk);
		wait (outstanding == 0);
		@(posedge clk);
	endtask

	initial begin : stimulus
		logic [15:0] pc;
		int          r;
		arst_n       = 1'b1;
		rec_valid    = 1'b0;
		rec_beat     = '0;
		no_gaps      = 1'b0;
		records_sent = 0;
		flushes_sent = 0;
		// reset edge lands after time zero so every process sees it
		#1;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// flush of an empty window
		send_beat(flush_beat(16'hFFFF, 8'hFF, 8'hFF));
		// run of three with a noise cycle inside, partial window flush
		send_beat(rec_beat_of(16'h1000, 8'h00, 8'h00));
		send_beat(rec_beat_of(16'h2000, 8'h11, 8'h80));
		send_beat(rec_beat_of(16'h1001, 8'hFF, 8'hFF));
		send_beat(rec_beat_of(16'h1002, 8'h5A, 8'h01));
		send_beat(rec_beat_of(16'h1003, 8'hA5, 8'h7F));
		send_beat(rec_beat_of(16'h1004, 8'h33, 8'hC3));
		send_beat(flush_beat(16'h1234, 8'h56, 8'h78));
		// address wrap, last record at top address meets the zero fill
		send_beat(rec_beat_of(16'hFFFE, 8'h12, 8'h40));
		send_beat(rec_beat_of(16'hFFFF, 8'h34, 8'h02));
		send_beat(rec_beat_of(16'h0000, 8'h56, 8'h20));
		send_beat(rec_beat_of(16'h0001, 8'h78, 8'h04));
		send_beat(rec_beat_of(16'hFFFF, 8'h9A, 8'h10));
		send_beat(flush_beat(16'h0000, 8'h00, 8'h00));
		// window overflow: repeats and out of order addresses
		send_beat(rec_beat_of(16'h8000, 8'h01, 8'hAA));
		send_beat(rec_beat_of(16'h8001, 8'h02, 8'h55));
		send_beat(rec_beat_of(16'h8001, 8'h03, 8'hF0));
		send_beat(rec_beat_of(16'h8003, 8'h04, 8'h0F));
		send_beat(rec_beat_of(16'h8002, 8'h05, 8'hCC));
		send_beat(rec_beat_of(16'h8003, 8'h06, 8'h33));
		send_beat(rec_beat_of(16'h0000, 8'h07, 8'h00));
		send_beat(rec_beat_of(16'hFFFF, 8'h08, 8'hFF));
		send_beat(rec_beat_of(16'h8004, 8'h09, 8'h81));
		send_beat(flush_beat(16'hA5A5, 8'h5A, 8'hA5));
		drain();

		// results held off while records keep coming at full rate
		hold_requests++;
		wait (holding);
		@(posedge clk);
		no_gaps = 1'b1;
		pc = 16'($urandom);
		for (int i = 0; i < HOLD_RECORDS; i++) begin
			send_beat(rec_beat_of(pc, 8'($urandom), 8'($urandom)));
			pc = ($urandom_range(4) == 0) ? 16'($urandom) : pc + 16'd1;
		end
		send_beat(flush_beat(16'($urandom), 8'($urandom), 8'($urandom)));
		no_gaps = 1'b0;

		// fetch streams with noise cycles, jumps and flushes
		pc = 16'($urandom);
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 25 == 0)
				no_gaps = ($urandom_range(3) == 0);
			if (i == RANDOM_ITEMS / 2) begin
				drain();
				@(posedge clk);
			end
			r = $urandom_range(99);
			if (r < 6) begin
				send_beat(flush_beat(16'($urandom), 8'($urandom), 8'($urandom)));
			end else if (r < 14) begin
				send_beat(rec_beat_of(16'($urandom), 8'($urandom), 8'($urandom)));
			end else begin
				if (r < 20) begin
					case ($urandom_range(3))
						0: pc = 16'hFFFC + 16'($urandom_range(3));
						1: pc = 16'($urandom_range(3));
						default: pc = 16'($urandom);
					endcase
				end
				send_beat(rec_beat_of(pc, 8'($urandom), 8'($urandom)));
				pc = pc + 16'd1;
			end
		end
		send_beat(flush_beat(16'($urandom), 8'($urandom), 8'($urandom)));
		drain();
		repeat (20) @(posedge clk);

		$display("Sent %0d record beats and %0d flush beats, incl. a long result hold.",
			records_sent, flushes_sent);
		$display("Compared %0d annotated results, %0d mismatches.", results_seen, mismatches);
		if (mismatches == 0 && outstanding == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin : ann_side
		int   holds_done;
		int   span;
		int   r;
		logic stall_v;
		ann_stall = 1'b0;
		holding = 1'b0;
		holds_done = 0;
		wait (arst_n === 1'b0);
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_requests != holds_done) begin
				holds_done = hold_requests;
				holding = 1'b1;
				stall_v = 1'b1;
				span = LONG_HOLD;
			end else begin
				holding = 1'b0;
				r = $urandom_range(99);
				if (r < 50) begin
					stall_v = 1'b0;
					span = $urandom_range(1, 4);
				end else if (r < 80) begin
					stall_v = 1'b1;
					span = $urandom_range(1, 3);
				end else if (r < 92) begin
					stall_v = 1'b0;
					span = $urandom_range(20, 60);
				end else begin
					stall_v = 1'b1;
					span = $urandom_range(8, 30);
				end
			end
			ann_stall <= stall_v;
			repeat (span) @(posedge clk);
		end
	end

	initial begin : watchdog
		#5_000_000;
		$display("Timeout with %0d results outstanding", outstanding);
		$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+design
design/btog_pkg.sv
design/btog_front.sv
design/btog_queue.sv
design/btog_back.sv
design/bus_trace_operand_gatherer_top.sv
design/btog_checker.sv
test/bus_trace_operand_gatherer_checker.sv
test/tb_bus_trace_operand_gatherer_top.sv
